/* rtl/core/vsat_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsat_pkg
// shared sizes, types, register codes and helpers of the volume prefix-sum core
// ----------------------------------------------------------------------------
package vsat_pkg;

   // largest volume the storage is built for
   localparam int unsigned MAX_WIDTH  = 256;
   localparam int unsigned MAX_HEIGHT = 256;
   localparam int unsigned MAX_DEPTH  = 256;

   localparam int unsigned CHANNELS  = 4;
   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned DIM_W     = 9;
   localparam int unsigned DIM_RESET = 256;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned OUT_W     = 32;

   // position and address widths
   localparam int unsigned X_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned Y_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int unsigned Z_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int unsigned CELL_N = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned CELL_W = (CELL_N > 1) ? $clog2(CELL_N) : 1;

   // sum widths: row, plane and full box
   localparam int unsigned ROW_W   = CHAN_W + $clog2(MAX_WIDTH);
   localparam int unsigned PLANE_W = ROW_W + $clog2(MAX_HEIGHT);
   localparam int unsigned SUM_W   = PLANE_W + $clog2(MAX_DEPTH);

   typedef logic [CHANNELS-1:0][CHAN_W-1:0]  chan_vec_type;
   typedef logic [CHANNELS-1:0][ROW_W-1:0]   row_vec_type;
   typedef logic [CHANNELS-1:0][PLANE_W-1:0] plane_vec_type;
   typedef logic [CHANNELS-1:0][SUM_W-1:0]   sum_vec_type;
   typedef logic [CHANNELS-1:0][OUT_W-1:0]   out_vec_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_DEPTH  = CSR_IDX_W'(2);

   // last coordinate in use for a dimension register: zero acts as one,
   // anything above the build size acts as the build size
   function automatic int unsigned dim_last(input logic [DIM_W-1:0] d,
                                            input int unsigned maxv);
      int unsigned v;
      v = 32'(d);
      if (v == 0) begin
         v = 1;
      end
      if (v > maxv) begin
         v = maxv;
      end
      return v - 1;
   endfunction

   // clip a box sum to the output width
   function automatic logic [OUT_W-1:0] saturate_sum(input logic [SUM_W-1:0] s);
      logic [SUM_W:0] ext;
      ext = {1'b0, s};
      if (ext > (SUM_W+1)'({OUT_W{1'b1}})) begin
         return {OUT_W{1'b1}};
      end
      return ext[OUT_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/core/volume_summed_area_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// path: a voxel transferred on req is registered in stage 1, and its sum then in
//   the output register that drives rsp
// throughput: one voxel per cycle when not stalled, set by the single read and
//   write port pair of the plane and row memories, each touched once per voxel
// stalls: an offered csr write holds voxels off and waits for stage 1 to drain
// reset: position, row sum and pipeline valids clear, dimensions go to 256;
//   the plane and row memories are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// volume_summed_area_table
// streaming 3d summed-area table over raster-ordered rgba voxels
// ----------------------------------------------------------------------------
module volume_summed_area_table (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // voxel input
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [vsat_pkg::CHAN_W-1:0]           req_red_in,
   input  wire logic [vsat_pkg::CHAN_W-1:0]           req_green_in,
   input  wire logic [vsat_pkg::CHAN_W-1:0]           req_blue_in,
   input  wire logic [vsat_pkg::CHAN_W-1:0]           req_alpha_in,
   // box sums out
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [vsat_pkg::OUT_W-1:0]                 rsp_red_sum,
   output logic [vsat_pkg::OUT_W-1:0]                 rsp_green_sum,
   output logic [vsat_pkg::OUT_W-1:0]                 rsp_blue_sum,
   output logic [vsat_pkg::OUT_W-1:0]                 rsp_alpha_sum,
   output logic                                       rsp_volume_done,
   // register writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [vsat_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [vsat_pkg::DIM_W-1:0]            csr_data
);

   // ------------------------------------------------------------------
   // configuration: kept as the last coordinate in use per axis
   // ------------------------------------------------------------------
   logic [vsat_pkg::X_W-1:0] lim_x_ff, lim_x_in;
   logic [vsat_pkg::Y_W-1:0] lim_y_ff, lim_y_in;
   logic [vsat_pkg::Z_W-1:0] lim_z_ff, lim_z_in;
   logic                     csr_fire;
   logic                     restart;

   // ------------------------------------------------------------------
   // stage 0: position, row running sum, memory read issue
   // ------------------------------------------------------------------
   logic [vsat_pkg::X_W-1:0]    pos_x_ff, pos_x_in;
   logic [vsat_pkg::Y_W-1:0]    pos_y_ff, pos_y_in;
   logic [vsat_pkg::Z_W-1:0]    pos_z_ff, pos_z_in;
   vsat_pkg::row_vec_type       row_sum_ff, row_sum_in;
   vsat_pkg::chan_vec_type      chan_in;
   vsat_pkg::row_vec_type       r0;
   logic [vsat_pkg::CELL_W-1:0] cell0;
   logic                        last_x, last_y, last_z;
   logic                        accept;

   // ------------------------------------------------------------------
   // stage 1: read data back, finish plane and box sums, write back
   // ------------------------------------------------------------------
   logic                        s1_vld_ff;
   vsat_pkg::row_vec_type       s1_r_ff;
   logic                        s1_ygate_ff;
   logic                        s1_zgate_ff;
   logic                        s1_done_ff;
   logic [vsat_pkg::X_W-1:0]    s1_x_ff;
   logic [vsat_pkg::CELL_W-1:0] s1_cell_ff;
   logic                        row_fwd_ff;
   vsat_pkg::plane_vec_type     row_fwd_data_ff;
   logic                        pl_fwd_ff;
   vsat_pkg::sum_vec_type       pl_fwd_data_ff;
   vsat_pkg::plane_vec_type     row_rd_ff;
   vsat_pkg::sum_vec_type       pl_rd_ff;
   vsat_pkg::plane_vec_type     p1;
   vsat_pkg::sum_vec_type       s1_sum;
   logic                        s1_go;

   // memories: in-plane sums of the latest row, box sums of the latest plane
   vsat_pkg::plane_vec_type row_mem [vsat_pkg::MAX_WIDTH];
   vsat_pkg::sum_vec_type   plane_mem [vsat_pkg::CELL_N];

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   logic                  rsp_valid_ff, rsp_valid_in;
   vsat_pkg::out_vec_type rsp_sum_ff;
   logic                  rsp_done_ff;

   // ------------------------------------------------------------------
   // handshakes
   // ------------------------------------------------------------------
   // stage 1 moves on whenever the output register is free or being drained
   assign s1_go     = s1_vld_ff && (!rsp_valid_ff || !rsp_stall);
   // voxels also hold off while a register write is offered
   assign req_stall = (s1_vld_ff && !s1_go) || csr_valid;
   assign accept    = req_valid && !req_stall;
   // register writes wait until no voxel still has a write-back pending
   assign csr_ready = !s1_vld_ff;
   assign csr_fire  = csr_valid && csr_ready;

   // ------------------------------------------------------------------
   // register write decode; any valid register restarts the volume
   // ------------------------------------------------------------------
   always_comb begin
      lim_x_in = lim_x_ff;
      lim_y_in = lim_y_ff;
      lim_z_in = lim_z_ff;
      restart  = 1'b0;
      if (csr_fire) begin
         case (csr_index)
            vsat_pkg::CSR_VOLUME_WIDTH: begin
               lim_x_in = vsat_pkg::X_W'(vsat_pkg::dim_last(csr_data, vsat_pkg::MAX_WIDTH));
               restart  = 1'b1;
            end
            vsat_pkg::CSR_VOLUME_HEIGHT: begin
               lim_y_in = vsat_pkg::Y_W'(vsat_pkg::dim_last(csr_data, vsat_pkg::MAX_HEIGHT));
               restart  = 1'b1;
            end
            vsat_pkg::CSR_VOLUME_DEPTH: begin
               lim_z_in = vsat_pkg::Z_W'(vsat_pkg::dim_last(csr_data, vsat_pkg::MAX_DEPTH));
               restart  = 1'b1;
            end
            default: begin
               // index past the register list: ignored
               restart = 1'b0;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // stage 0 datapath
   // ------------------------------------------------------------------
   assign chan_in = {req_alpha_in, req_blue_in, req_green_in, req_red_in};

   assign last_x = (pos_x_ff == lim_x_ff);
   assign last_y = (pos_y_ff == lim_y_ff);
   assign last_z = (pos_z_ff == lim_z_ff);

   // raster address of the plane entry under this voxel
   assign cell0 = vsat_pkg::CELL_W'(pos_y_ff) * vsat_pkg::CELL_W'(vsat_pkg::MAX_WIDTH)
                + vsat_pkg::CELL_W'(pos_x_ff);

   // running sum along the row, empty at the row start
   always_comb begin
      for (int c = 0; c < vsat_pkg::CHANNELS; c++) begin
         r0[c] = vsat_pkg::ROW_W'(chan_in[c])
               + ((pos_x_ff == '0) ? '0 : row_sum_ff[c]);
      end
   end

   // position walk: x fastest, then y, then z, wrapping at the volume end
   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      pos_z_in   = pos_z_ff;
      row_sum_in = row_sum_ff;
      if (restart) begin
         pos_x_in   = '0;
         pos_y_in   = '0;
         pos_z_in   = '0;
         row_sum_in = '0;
      end else if (accept) begin
         row_sum_in = r0;
         if (!last_x) begin
            pos_x_in = pos_x_ff + 1'b1;
         end else begin
            pos_x_in = '0;
            if (!last_y) begin
               pos_y_in = pos_y_ff + 1'b1;
            end else begin
               pos_y_in = '0;
               pos_z_in = last_z ? '0 : pos_z_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_x_ff   <= vsat_pkg::X_W'(vsat_pkg::dim_last(
                          vsat_pkg::DIM_W'(vsat_pkg::DIM_RESET), vsat_pkg::MAX_WIDTH));
         lim_y_ff   <= vsat_pkg::Y_W'(vsat_pkg::dim_last(
                          vsat_pkg::DIM_W'(vsat_pkg::DIM_RESET), vsat_pkg::MAX_HEIGHT));
         lim_z_ff   <= vsat_pkg::Z_W'(vsat_pkg::dim_last(
                          vsat_pkg::DIM_W'(vsat_pkg::DIM_RESET), vsat_pkg::MAX_DEPTH));
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         pos_z_ff   <= '0;
         row_sum_ff <= '0;
      end else begin
         lim_x_ff   <= lim_x_in;
         lim_y_ff   <= lim_y_in;
         lim_z_ff   <= lim_z_in;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         pos_z_ff   <= pos_z_in;
         row_sum_ff <= row_sum_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1 control and payload
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (accept) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_go) begin
         s1_vld_ff <= 1'b0;
      end
   end

   // the voxel ahead writes back at the very edge this one reads, so its
   // result is captured here when both hit the same entry
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_r_ff         <= r0;
         s1_ygate_ff     <= (pos_y_ff != '0);
         s1_zgate_ff     <= (pos_z_ff != '0);
         s1_done_ff      <= last_x && last_y && last_z;
         s1_x_ff         <= pos_x_ff;
         s1_cell_ff      <= cell0;
         row_fwd_ff      <= s1_go && (s1_x_ff == pos_x_ff);
         row_fwd_data_ff <= p1;
         pl_fwd_ff       <= s1_go && (s1_cell_ff == cell0);
         pl_fwd_data_ff  <= s1_sum;
      end
   end

   // memory reads issue on the transfer, write-back as stage 1 leaves
   always_ff @(posedge clock) begin
      if (s1_go) begin
         row_mem[s1_x_ff] <= p1;
      end
      if (accept) begin
         row_rd_ff <= row_mem[pos_x_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         plane_mem[s1_cell_ff] <= s1_sum;
      end
      if (accept) begin
         pl_rd_ff <= plane_mem[cell0];
      end
   end

   // plane sum adds the row above, box sum adds the plane below
   always_comb begin
      for (int c = 0; c < vsat_pkg::CHANNELS; c++) begin
         p1[c] = vsat_pkg::PLANE_W'(s1_r_ff[c])
               + (!s1_ygate_ff ? '0 : (row_fwd_ff ? row_fwd_data_ff[c] : row_rd_ff[c]));
         s1_sum[c] = vsat_pkg::SUM_W'(p1[c])
                   + (!s1_zgate_ff ? '0 : (pl_fwd_ff ? pl_fwd_data_ff[c] : pl_rd_ff[c]));
      end
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   assign rsp_valid_in = s1_go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         for (int c = 0; c < vsat_pkg::CHANNELS; c++) begin
            rsp_sum_ff[c] <= vsat_pkg::saturate_sum(s1_sum[c]);
         end
         rsp_done_ff <= s1_done_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_sum     = rsp_sum_ff[0];
   assign rsp_green_sum   = rsp_sum_ff[1];
   assign rsp_blue_sum    = rsp_sum_ff[2];
   assign rsp_alpha_sum   = rsp_sum_ff[3];
   assign rsp_volume_done = rsp_done_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // the position never runs past the extent in use
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (pos_x_ff <= lim_x_ff) && (pos_y_ff <= lim_y_ff) && (pos_z_ff <= lim_z_ff))
      else $error("position beyond volume extent");

   // the last voxel of a volume sends the walk back to the origin
   a_wrap_origin: assert property (@(posedge clock) disable iff (reset)
      accept && last_x && last_y && last_z
      |=> (pos_x_ff == '0) && (pos_y_ff == '0) && (pos_z_ff == '0))
      else $error("position did not wrap after last voxel");

   // a held stage 1 voxel is never dropped
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s1_go |=> s1_vld_ff && $stable(s1_cell_ff))
      else $error("stage 1 voxel lost while stalled");

endmodule
`default_nettype wire

/* tb/tb_volume_summed_area_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_volume_summed_area_table
// self-checking bench for the streaming 3d summed-area table: a short table of
// directed voxels and register writes, then randomly sized volumes streamed
// under random sender and receiver idling, sums checked by table or predictor
// ----------------------------------------------------------------------------
module tb_volume_summed_area_table;

   localparam int unsigned HALF_PERIOD   = 5;
   localparam int unsigned RESET_CYCLES  = 7;
   localparam int unsigned RANDOM_VOXELS = 1600;
   localparam int unsigned QUIET_LIMIT   = 4000;
   localparam int unsigned DRAIN_CYCLES  = 4;
   localparam int unsigned MAX_REPORTS   = 10;
   localparam int unsigned NCH           = vsat_pkg::CHANNELS;

   // index past the register list, writes to it are dropped
   localparam logic [vsat_pkg::CSR_IDX_W-1:0] CSR_SPARE = vsat_pkg::CSR_IDX_W'(3);

   typedef enum int unsigned {
      IDLE_SENDER_LIGHT,
      IDLE_SENDER_HEAVY,
      IDLE_NONE
   } idle_mode_type;

   // one box sum per voxel, channel 0 is red
   typedef struct {
      vsat_pkg::out_vec_type sum;
      logic                  done;
   } box_sum_type;

   // one row of the directed table: a register write or a voxel
   typedef struct {
      bit                               is_write;
      logic [vsat_pkg::CSR_IDX_W-1:0]   index;
      logic [vsat_pkg::DIM_W-1:0]       data;
      vsat_pkg::chan_vec_type           color;
      bit                               typed;
      box_sum_type                      want;
   } stim_row_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // voxel input channel
   logic                          req_valid    = 1'b0;
   logic                          req_stall;
   logic [vsat_pkg::CHAN_W-1:0]   req_red_in   = '0;
   logic [vsat_pkg::CHAN_W-1:0]   req_green_in = '0;
   logic [vsat_pkg::CHAN_W-1:0]   req_blue_in  = '0;
   logic [vsat_pkg::CHAN_W-1:0]   req_alpha_in = '0;

   // sum output channel
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [vsat_pkg::OUT_W-1:0]    rsp_red_sum;
   logic [vsat_pkg::OUT_W-1:0]    rsp_green_sum;
   logic [vsat_pkg::OUT_W-1:0]    rsp_blue_sum;
   logic [vsat_pkg::OUT_W-1:0]    rsp_alpha_sum;
   logic                          rsp_volume_done;

   // register write channel
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [vsat_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [vsat_pkg::DIM_W-1:0]        csr_data  = '0;

   // predictor copy of the registers and the running sums
   logic [vsat_pkg::DIM_W-1:0] width_reg  = vsat_pkg::DIM_W'(vsat_pkg::DIM_RESET);
   logic [vsat_pkg::DIM_W-1:0] height_reg = vsat_pkg::DIM_W'(vsat_pkg::DIM_RESET);
   logic [vsat_pkg::DIM_W-1:0] depth_reg  = vsat_pkg::DIM_W'(vsat_pkg::DIM_RESET);
   bit [63:0]   plane_acc [vsat_pkg::CELL_N][NCH];
   bit [63:0]   row_acc [vsat_pkg::MAX_WIDTH][NCH];
   bit [63:0]   run_acc [NCH];
   int unsigned at_x = 0;
   int unsigned at_y = 0;
   int unsigned at_z = 0;

   // sums still owed by the block, oldest first
   box_sum_type  pending_box_sums [$];
   stim_row_type directed_rows [$];
   box_sum_type  blank_sum;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // run statistics
   int unsigned voxels_sent     = 0;
   int unsigned sums_checked    = 0;
   int unsigned volumes_done    = 0;
   int unsigned register_writes = 0;
   int unsigned mismatches      = 0;
   int unsigned quiet_cycles    = 0;

   string channel_names [NCH] = '{"red_sum", "green_sum", "blue_sum", "alpha_sum"};

   always #(HALF_PERIOD) clock = ~clock;

   volume_summed_area_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_alpha_in    (req_alpha_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red_sum     (rsp_red_sum),
      .rsp_green_sum   (rsp_green_sum),
      .rsp_blue_sum    (rsp_blue_sum),
      .rsp_alpha_sum   (rsp_alpha_sum),
      .rsp_volume_done (rsp_volume_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // zero acts as one, anything past the build size acts as the build size
   function automatic int unsigned effective_dim(logic [vsat_pkg::DIM_W-1:0] raw,
                                                 int unsigned limit);
      if (raw == 0) begin
         return 1;
      end
      if (int'(raw) > limit) begin
         return limit;
      end
      return int'(raw);
   endfunction

   // box sum of the next voxel in raster order, then step the position
   function automatic box_sum_type predict_box_sums(vsat_pkg::chan_vec_type color);
      box_sum_type res;
      int unsigned w;
      int unsigned h;
      int unsigned d;
      int unsigned slot;
      int          c;
      bit [63:0]   r;
      bit [63:0]   p;
      bit [63:0]   s;
      w    = effective_dim(width_reg, vsat_pkg::MAX_WIDTH);
      h    = effective_dim(height_reg, vsat_pkg::MAX_HEIGHT);
      d    = effective_dim(depth_reg, vsat_pkg::MAX_DEPTH);
      slot = at_y * vsat_pkg::MAX_WIDTH + at_x;
      for (c = 0; c < NCH; c++) begin
         // terms at coordinate -1 are zero, so stored sums of this volume only
         r = 64'(color[c]) + ((at_x == 0) ? 64'd0 : run_acc[c]);
         p = r + ((at_y == 0) ? 64'd0 : row_acc[at_x][c]);
         s = p + ((at_z == 0) ? 64'd0 : plane_acc[slot][c]);
         run_acc[c]         = r;
         row_acc[at_x][c]   = p;
         plane_acc[slot][c] = s;
         res.sum[c] = (s > 64'hFFFF_FFFF) ? '1 : s[31:0];
      end
      res.done = (at_x + 1 == w) && (at_y + 1 == h) && (at_z + 1 == d);
      // raster step, wrapping to the origin after the last voxel
      if (at_x + 1 < w) begin
         at_x++;
      end else begin
         at_x = 0;
         if (at_y + 1 < h) begin
            at_y++;
         end else begin
            at_y = 0;
            at_z = (at_z + 1 < d) ? at_z + 1 : 0;
         end
      end
      return res;
   endfunction

   function automatic void select_idling(idle_mode_type mode);
      case (mode)
         IDLE_SENDER_LIGHT: begin
            send_idle_pct = 29;
            recv_idle_pct = 76;
         end
         IDLE_SENDER_HEAVY: begin
            send_idle_pct = 76;
            recv_idle_pct = 29;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endfunction

   function automatic vsat_pkg::chan_vec_type rgba(int unsigned r, int unsigned g,
                                                   int unsigned b, int unsigned a);
      return {8'(a), 8'(b), 8'(g), 8'(r)};
   endfunction

   function automatic box_sum_type sums(int unsigned r, int unsigned g, int unsigned b,
                                        int unsigned a, bit done);
      box_sum_type res;
      res.sum  = {32'(a), 32'(b), 32'(g), 32'(r)};
      res.done = done;
      return res;
   endfunction

   function automatic stim_row_type csr_row(logic [vsat_pkg::CSR_IDX_W-1:0] idx,
                                            logic [vsat_pkg::DIM_W-1:0] val);
      stim_row_type row;
      row.is_write = 1'b1;
      row.index    = idx;
      row.data     = val;
      row.color    = '0;
      row.typed    = 1'b0;
      return row;
   endfunction

   function automatic stim_row_type voxel_row(vsat_pkg::chan_vec_type color, bit typed,
                                              box_sum_type want);
      stim_row_type row;
      row.is_write = 1'b0;
      row.index    = '0;
      row.data     = '0;
      row.color    = color;
      row.typed    = typed;
      row.want     = want;
      return row;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch at sum %0d, %s: expected %0d, got %0d",
                  sums_checked, what, want, got);
      end
   endtask

   // one voxel transfer, with random idle cycles ahead of it
   task automatic push_voxel(vsat_pkg::chan_vec_type color, bit typed, box_sum_type want);
      box_sum_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= color[0];
      req_green_in <= color[1];
      req_blue_in  <= color[2];
      req_alpha_in <= color[3];
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      // predictor always runs so its state follows the block
      predicted = predict_box_sums(color);
      pending_box_sums.push_back(typed ? want : predicted);
      voxels_sent++;
   endtask

   // register write, only once every owed sum has come back
   task automatic write_register(logic [vsat_pkg::CSR_IDX_W-1:0] idx,
                                 logic [vsat_pkg::DIM_W-1:0] val);
      int c;
      req_valid <= 1'b0;
      while (pending_box_sums.size() != 0) begin
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      register_writes++;
      if (idx != CSR_SPARE) begin
         case (idx)
            vsat_pkg::CSR_VOLUME_WIDTH:  width_reg  = val;
            vsat_pkg::CSR_VOLUME_HEIGHT: height_reg = val;
            vsat_pkg::CSR_VOLUME_DEPTH:  depth_reg  = val;
            default: ;
         endcase
         // any real write restarts the volume at the origin
         at_x = 0;
         at_y = 0;
         at_z = 0;
         for (c = 0; c < NCH; c++) begin
            run_acc[c] = 64'd0;
         end
      end
      // gap so a following write raises valid in a later step
      @(posedge clock);
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // compare each sum transfer with the oldest owed sum
   always @(posedge clock) begin : check_sums
      box_sum_type           want;
      vsat_pkg::out_vec_type got;
      int                    c;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_alpha_sum, rsp_blue_sum, rsp_green_sum, rsp_red_sum};
         if (pending_box_sums.size() == 0) begin
            flag_mismatch("sum with none owed", 32'd0, rsp_red_sum);
         end else begin
            want = pending_box_sums.pop_front();
            for (c = 0; c < NCH; c++) begin
               if (got[c] !== want.sum[c]) begin
                  flag_mismatch(channel_names[c], want.sum[c], got[c]);
               end
            end
            if (rsp_volume_done !== want.done) begin
               flag_mismatch("volume_done", 32'(want.done), 32'(rsp_volume_done));
            end
            if (want.done) begin
               volumes_done++;
            end
            sums_checked++;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no transfer for %0d cycles", quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int unsigned                    random_start;
      int unsigned                    burst;
      int unsigned                    vol;
      int unsigned                    first;
      int unsigned                    k;
      int unsigned                    c;
      int unsigned                    pick;
      logic [vsat_pkg::DIM_W-1:0]     dim_vals [3];
      logic [vsat_pkg::CSR_IDX_W-1:0] dim_codes [3];
      vsat_pkg::chan_vec_type         color;

      blank_sum.sum  = '0;
      blank_sum.done = 1'b0;

      dim_codes[0] = vsat_pkg::CSR_VOLUME_WIDTH;
      dim_codes[1] = vsat_pkg::CSR_VOLUME_HEIGHT;
      dim_codes[2] = vsat_pkg::CSR_VOLUME_DEPTH;

      // directed table, sums typed in only where obvious
      // reset dims, first voxels of a wide row
      directed_rows.push_back(voxel_row(rgba(255, 0, 255, 0), 1'b1,
                                        sums(255, 0, 255, 0, 1'b0)));
      directed_rows.push_back(voxel_row(rgba(1, 2, 3, 4), 1'b1,
                                        sums(256, 2, 258, 4, 1'b0)));
      // write past the register list leaves the position alone
      directed_rows.push_back(csr_row(CSR_SPARE, 9'h1FF));
      directed_rows.push_back(voxel_row(rgba(0, 0, 0, 0), 1'b1,
                                        sums(256, 2, 258, 4, 1'b0)));
      // single-voxel volume, every voxel ends a volume
      directed_rows.push_back(csr_row(vsat_pkg::CSR_VOLUME_WIDTH, 9'd1));
      directed_rows.push_back(csr_row(vsat_pkg::CSR_VOLUME_HEIGHT, 9'd1));
      directed_rows.push_back(csr_row(vsat_pkg::CSR_VOLUME_DEPTH, 9'd1));
      directed_rows.push_back(voxel_row(rgba(255, 255, 255, 255), 1'b1,
                                        sums(255, 255, 255, 255, 1'b1)));
      directed_rows.push_back(voxel_row(rgba(0, 0, 0, 0), 1'b1,
                                        sums(0, 0, 0, 0, 1'b1)));
      // zero width acts as one
      directed_rows.push_back(csr_row(vsat_pkg::CSR_VOLUME_WIDTH, 9'd0));
      directed_rows.push_back(voxel_row(rgba(7, 8, 9, 10), 1'b1,
                                        sums(7, 8, 9, 10, 1'b1)));
      // width above the build size clips, zero height and depth act as one
      directed_rows.push_back(csr_row(vsat_pkg::CSR_VOLUME_WIDTH, 9'h1FF));
      directed_rows.push_back(csr_row(vsat_pkg::CSR_VOLUME_HEIGHT, 9'd0));
      directed_rows.push_back(csr_row(vsat_pkg::CSR_VOLUME_DEPTH, 9'd0));
      directed_rows.push_back(voxel_row(rgba(255, 255, 255, 255), 1'b1,
                                        sums(255, 255, 255, 255, 1'b0)));
      directed_rows.push_back(voxel_row(rgba(255, 255, 255, 255), 1'b1,
                                        sums(510, 510, 510, 510, 1'b0)));
      // full 2x2x2 cube through every inclusion-exclusion term
      directed_rows.push_back(csr_row(vsat_pkg::CSR_VOLUME_WIDTH, 9'd2));
      directed_rows.push_back(csr_row(vsat_pkg::CSR_VOLUME_HEIGHT, 9'd2));
      directed_rows.push_back(csr_row(vsat_pkg::CSR_VOLUME_DEPTH, 9'd2));
      directed_rows.push_back(voxel_row(rgba(255, 0, 17, 128), 1'b0, blank_sum));
      directed_rows.push_back(voxel_row(rgba(1, 254, 128, 64), 1'b0, blank_sum));
      directed_rows.push_back(voxel_row(rgba(0, 255, 85, 170), 1'b0, blank_sum));
      directed_rows.push_back(voxel_row(rgba(128, 127, 2, 253), 1'b0, blank_sum));
      // dropped write between planes must not restart the cube
      directed_rows.push_back(csr_row(CSR_SPARE, 9'd0));
      directed_rows.push_back(voxel_row(rgba(255, 255, 255, 255), 1'b0, blank_sum));
      directed_rows.push_back(voxel_row(rgba(0, 0, 0, 0), 1'b0, blank_sum));
      directed_rows.push_back(voxel_row(rgba(60, 70, 80, 90), 1'b0, blank_sum));
      directed_rows.push_back(voxel_row(rgba(200, 100, 50, 25), 1'b0, blank_sum));

      // synchronous reset, held only at the start
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      select_idling(IDLE_SENDER_LIGHT);
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            write_register(directed_rows[i].index, directed_rows[i].data);
         end else begin
            push_voxel(directed_rows[i].color, directed_rows[i].typed,
                       directed_rows[i].want);
         end
      end

      // random volumes; idling mode moves on by thirds of the voxel budget
      random_start = voxels_sent;
      while (voxels_sent < random_start + RANDOM_VOXELS) begin
         select_idling(idle_mode_type'(((voxels_sent - random_start) * 3) / RANDOM_VOXELS));
         if ($urandom_range(99) < 15) begin
            // keep going in the current volume, maybe with a dropped write
            if ($urandom_range(1) == 0) begin
               write_register(CSR_SPARE, 9'($urandom_range(511)));
            end
            burst = $urandom_range(1, 40);
         end else begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               // extremes: long rows, tall planes, deep stacks, clipped values
               case ($urandom_range(4))
                  0: begin
                     dim_vals[0] = 9'($urandom_range(256, 511));
                     dim_vals[1] = 9'd1;
                     dim_vals[2] = 9'($urandom_range(1, 2));
                  end
                  1: begin
                     dim_vals[0] = 9'($urandom_range(1, 2));
                     dim_vals[1] = 9'($urandom_range(256, 300));
                     dim_vals[2] = 9'd1;
                  end
                  2: begin
                     dim_vals[0] = 9'd1;
                     dim_vals[1] = 9'($urandom_range(0, 1));
                     dim_vals[2] = 9'($urandom_range(256, 511));
                  end
                  3: begin
                     dim_vals[0] = 9'd16;
                     dim_vals[1] = 9'd16;
                     dim_vals[2] = 9'($urandom_range(1, 2));
                  end
                  default: begin
                     dim_vals[0] = 9'd0;
                     dim_vals[1] = 9'd0;
                     dim_vals[2] = 9'd0;
                  end
               endcase
            end else begin
               // small volumes, zero now and then
               dim_vals[0] = 9'($urandom_range(0, 8));
               dim_vals[1] = 9'($urandom_range(0, 6));
               dim_vals[2] = 9'($urandom_range(0, 5));
            end
            first = $urandom_range(2);
            for (k = 0; k < 3; k++) begin
               write_register(dim_codes[(first + k) % 3], dim_vals[(first + k) % 3]);
            end
            if ($urandom_range(4) == 0) begin
               write_register(CSR_SPARE, 9'($urandom_range(511)));
            end
            vol = effective_dim(width_reg, vsat_pkg::MAX_WIDTH) *
                  effective_dim(height_reg, vsat_pkg::MAX_HEIGHT) *
                  effective_dim(depth_reg, vsat_pkg::MAX_DEPTH);
            // whole volumes, sometimes ending partway into the next one
            burst = vol * ((vol > 64) ? 1 : $urandom_range(1, 2));
            if ($urandom_range(2) == 0) begin
               burst += $urandom_range(vol - 1);
            end
         end
         // the voxel budget cuts the last burst short
         for (k = 0; k < burst && voxels_sent < random_start + RANDOM_VOXELS; k++) begin
            for (c = 0; c < NCH; c++) begin
               pick = $urandom_range(9);
               color[c] = (pick == 0) ? 8'd0 :
                          (pick == 1) ? 8'd255 : 8'($urandom_range(255));
            end
            push_voxel(color, 1'b0, blank_sum);
         end
      end

      // drain the owed sums, then keep the clock running for stray transfers
      req_valid <= 1'b0;
      while (pending_box_sums.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d voxels and %0d checked sums over %0d finished volumes",
               voxels_sent, sums_checked, volumes_done);
      $display("with %0d register writes and %0d mismatches", register_writes,
               mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
